[sv/stli_pkg.sv]
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants
// Table depth, request and status codes, cell control struct.
// ----------------------------------------------------------------------------
package stli_pkg;
	localparam int TableDepth = 64;
	localparam int CntW = $clog2(TableDepth + 1);

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic        load;
		logic        shift;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} cell_ctl_t;
endpackage

[sv/stli_cell.sv]
// ----------------------------------------------------------------------------
// stli_cell: one table slot
// Holds one point; on insert it either keeps, takes the new point or takes
// its left neighbour's point. During a scan it shifts its point rightwards.
// ----------------------------------------------------------------------------
module stli_cell (
	input  logic                       clk,
	input  stli_pkg::cell_ctl_t        ctl,
	input  logic                       valid_in,   // this slot holds a point
	input  logic                       left_gt,    // left neighbour x > new x
	input  logic                       left_valid,
	input  logic signed [15:0]         left_x,
	input  logic signed [15:0]         left_y,
	output logic signed [15:0]         x_q,
	output logic signed [15:0]         y_q,
	output logic                       gt
);
	import stli_pkg::*;

	assign gt = valid_in && (x_q > ctl.x);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (left_valid && left_gt) begin
				x_q <= left_x;
				y_q <= left_y;
			end else if (!valid_in || gt) begin
				if (!valid_in || !(left_valid && left_gt)) begin
					x_q <= ctl.x;
					y_q <= ctl.y;
				end
			end
		end else if (ctl.shift) begin
			x_q <= left_x;
			y_q <= left_y;
		end
	end
endmodule

[sv/stli_div.sv]
// ----------------------------------------------------------------------------
// stli_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module stli_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic signed [16:0] den,
	output logic               done,
	output logic signed [32:0] quo
);
	import stli_pkg::*;

	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [16:0] dabs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], quo_q[32]} - {17'd0, dabs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
				rem_q  <= '0;
				quo_q  <= num[32] ? 33'(-num) : 33'(num);
				dabs_q <= den[16] ? 17'(-den) : 17'(den);
				neg_q  <= num[32] ^ den[16];
			end else if (busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], quo_q[32]};
					quo_q <= {quo_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? 33'(-quo_q) : 33'(quo_q);
endmodule

[sv/sorted_table_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: sorted x/y table with interpolation
// Row of table cells plus a scan sequencer and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_ready) carries req_type, point_x, point_y;
//  out channel (out_valid/out_ready) carries result_y and status, one beat
//  per request.
//  A load is written into the row of cells in the S_LOAD state: every
//  cell compares its x with the new x and either keeps its point, takes
//  the new one or takes its left neighbour's. Its result beat is raised
//  from S_LOAD; a clear, an unused code, a load into a full table and a
//  query on an empty table answer in the cycle after the request beat.
//  A query rotates the row of cells past the last slot, one entry a cycle,
//  through the full table depth, then checks in S_WAIT: an exact match or
//  an out of range query answers from there. An interpolated query forms
//  the product there and goes on through S_MUL, which starts the serial
//  divider, and S_DIV. One request is in work at a time; the next is taken
//  in the cycle after the result beat has been accepted.
//  Reset empties the table (the count goes to zero) and drops any request.
//  A stalled receiver holds the result beat; in_ready stays low until it
//  has been taken.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] result_y,
	output logic [1:0]         status
);
	import stli_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_MUL, S_DIV, S_WAIT} fsm_t;
	fsm_t state_q;

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] rot_q;      // rotations done
	logic signed [15:0] qx_q, qy_q;
	logic               found_q, brk_q;
	logic signed [15:0] xlo_q, ylo_q, xhi_q, yhi_q, first_x_q;
	logic signed [15:0] eq_y_q, hi_last_q;
	logic signed [16:0] dx, dy;
	logic signed [32:0] num_q;
	logic signed [16:0] den_q;
	logic               div_start;
	logic               div_done;
	logic signed [32:0] quo;

	cell_ctl_t ctl;
	logic signed [15:0] cx [TableDepth];
	logic signed [15:0] cy [TableDepth];
	logic               cgt [TableDepth];
	logic               cval [TableDepth];

	assign ctl.load  = (state_q == S_LOAD);
	assign ctl.shift = (state_q == S_SCAN);
	assign ctl.x     = qx_q;
	assign ctl.y     = qy_q;

	genvar g;
	generate
		for (g = 0; g < TableDepth; g++) begin : g_cell
			logic signed [15:0] lx, ly;
			logic lv, lg;
			if (g == 0) begin : g_first
				// during scan the row rotates: last slot feeds the first
				assign lx = cx[TableDepth-1];
				assign ly = cy[TableDepth-1];
				assign lv = 1'b0;
				assign lg = 1'b0;
			end else begin : g_rest
				assign lx = cx[g-1];
				assign ly = cy[g-1];
				assign lv = cval[g-1];
				assign lg = cgt[g-1];
			end
			assign cval[g] = (CntW'(g) < count_q);
			stli_cell u_cell (
				.clk(clk), .ctl(ctl), .valid_in(cval[g]),
				.left_gt(lg), .left_valid(lv), .left_x(lx), .left_y(ly),
				.x_q(cx[g]), .y_q(cy[g]), .gt(cgt[g])
			);
		end
	endgenerate

	// slot that the scan looks at: after r rotations, slot TableDepth-1
	// holds entry TableDepth-1-r; so rotate the full depth and look at
	// slot TableDepth-1 throughout
	logic signed [15:0] tail_x, tail_y;
	assign tail_x = cx[TableDepth-1];
	assign tail_y = cy[TableDepth-1];

	// rotation k (0-based) shows entry TableDepth-1-k in the tail slot;
	// track entry index directly
	logic [CntW-1:0] ent;
	assign ent = CntW'((TableDepth - 1 + TableDepth - int'(rot_q)) % TableDepth);

	// bracket differences at 17 bits so they cannot wrap
	assign dx = 17'(qx_q) - 17'(xlo_q);
	assign dy = 17'(yhi_q) - 17'(ylo_q);

	stli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_q), .den(den_q), .done(div_done), .quo(quo)
	);
	assign div_start = (state_q == S_MUL);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
			rot_q     <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						qx_q <= point_x;
						qy_q <= point_y;
						result_y <= '0;
						case (req_t'(req_type))
							REQ_LOAD: begin
								if (count_q >= CntW'(TableDepth)) begin
									status <= ST_FULL;
									out_valid <= 1'b1;
								end else begin
									status <= ST_OK;
									state_q <= S_LOAD;
								end
							end
							REQ_QUERY: begin
								if (count_q == '0) begin
									status <= ST_EMPTY;
									out_valid <= 1'b1;
								end else begin
									status  <= ST_OK;
									state_q <= S_SCAN;
									rot_q   <= '0;
									found_q <= 1'b0;
									brk_q   <= 1'b0;
								end
							end
							REQ_CLEAR: begin
								status <= ST_OK;
								count_q <= '0;
								out_valid <= 1'b1;
							end
							default: begin
								status <= ST_OK;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				S_LOAD: begin
					count_q <= count_q + 1'b1;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// tail slot holds entry ent; entries walked high to low
					if (ent < count_q) begin
						if (ent == '0) first_x_q <= tail_x;
						if (tail_x == qx_q) begin
							found_q <= 1'b1;
							ylo_q   <= tail_y; // lowest index wins: walked last
						end else if (tail_x < qx_q && !brk_q) begin
							brk_q <= 1'b1;
							xlo_q <= tail_x;
							ylo_q <= found_q ? ylo_q : tail_y;
						end else if (tail_x > qx_q && !brk_q) begin
							xhi_q <= tail_x;
							yhi_q <= tail_y;
						end
					end
					rot_q <= rot_q + 1'b1;
					if (rot_q == CntW'(TableDepth - 1)) state_q <= S_WAIT;
				end
				S_WAIT: begin
					// row is back in place after a full rotation
					if (qx_q < first_x_q || qx_q > hi_last_q) begin
						status <= ST_RANGE;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (found_q) begin
						result_y <= eq_y_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						num_q <= 33'(dx) * 33'(dy);
						den_q <= 17'(xhi_q) - 17'(xlo_q);
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						result_y <= 16'(ylo_q + 16'(quo));
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// exact-match y and last x kept apart from the bracket
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && ent < count_q) begin
			if (tail_x == qx_q) eq_y_q <= tail_y;
			if (ent == count_q - 1'b1) hi_last_q <= tail_x;
		end
	end

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while busy");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_IDLE)
		else $error("result shown while working");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TableDepth))
		else $error("point count overflow");
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_table_linear_interpolator
// Drives loads, queries and clears through the input channel. A copy of the
// sorted point table predicts each result beat, and the scoreboard compares
// every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import stli_pkg::*;

	class interp_scoreboard;
		logic signed [15:0] tab_x[$];
		logic signed [15:0] tab_y[$];
		logic signed [15:0] want_y[$];
		status_t            want_st[$];
		int                 errors;

		function void note_request(req_t rq, logic signed [15:0] px,
			logic signed [15:0] py);
			logic signed [15:0] ry;
			status_t st;
			int pos;
			int n;
			longint num;
			longint den;
			ry = '0;
			st = ST_OK;
			n = tab_x.size();
			case (rq)
				REQ_LOAD: begin
					if (n >= TableDepth) begin
						st = ST_FULL;
					end else begin
						// stable: goes after every equal x
						pos = n;
						while (pos > 0 && tab_x[pos-1] > px) pos--;
						tab_x.insert(pos, px);
						tab_y.insert(pos, py);
					end
				end
				REQ_QUERY: begin
					if (n == 0) begin
						st = ST_EMPTY;
					end else if (px < tab_x[0] || px > tab_x[n-1]) begin
						st = ST_RANGE;
					end else begin
						pos = -1;
						for (int i = 0; i < n; i++)
							if (pos < 0 && tab_x[i] == px) pos = i;
						if (pos >= 0) begin
							ry = tab_y[pos];
						end else begin
							for (int i = 0; i + 1 < n; i++)
								if (pos < 0 && px > tab_x[i] && px < tab_x[i+1]) begin
									pos = i;
									num = (longint'(px) - longint'(tab_x[i])) *
										(longint'(tab_y[i+1]) - longint'(tab_y[i]));
									den = longint'(tab_x[i+1]) - longint'(tab_x[i]);
									ry = 16'(longint'(tab_y[i]) + num / den);
								end
						end
					end
				end
				REQ_CLEAR: begin
					tab_x.delete();
					tab_y.delete();
				end
				default: ;
			endcase
			want_y = {want_y, ry};
			want_st = {want_st, st};
		endfunction

		function void check_result(logic signed [15:0] ry, logic [1:0] st);
			logic signed [15:0] ey;
			status_t es;
			if (want_y.size() == 0) begin
				$display("%0t: unexpected result beat y=%0d status=%0d", $time, ry, st);
				errors++;
				return;
			end
			ey = want_y.pop_front();
			es = want_st.pop_front();
			if (ry !== ey) begin
				$display("%0t: result_y expected %0d actual %0d", $time, ey, ry);
				errors++;
			end
			if (st !== es) begin
				$display("%0t: status expected %0d actual %0d", $time, es, st);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_NONE;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] result_y;
	logic [1:0]         status;

	interp_scoreboard sb = new();
	int     send_idle;
	int     recv_stall;
	bit     hold_off;
	longint cycles;
	logic signed [15:0] pool_x[$];

	always #1 clk = ~clk;

	sorted_table_linear_interpolator dut (.*);

	task automatic send_req(req_t rq, logic signed [15:0] px, logic signed [15:0] py);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= rq;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(rq, px, py);
	endtask

	function automatic logic signed [15:0] pick_x();
		logic signed [15:0] v;
		case ($urandom_range(5))
			0: v = 16'($urandom);
			1: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: v = pool_x.size() ? pool_x[$urandom_range(pool_x.size()-1)] +
				$signed(16'($urandom_range(6))) - 16'sd3 : 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic rand_item();
		int r;
		logic signed [15:0] px;
		r = $urandom_range(99);
		px = pick_x();
		if (r < 45) begin
			pool_x = {pool_x, px};
			send_req(REQ_LOAD, px, 16'($urandom));
		end else if (r < 93) begin
			send_req(REQ_QUERY, px, 16'($urandom));
		end else if (r < 97) begin
			pool_x.delete();
			send_req(REQ_CLEAR, px, 16'($urandom));
		end else begin
			send_req(REQ_NONE, px, 16'($urandom));
		end
	endtask

	// receiver side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(result_y, status);
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty, extremes, duplicates, full table, clear, unused code
		send_req(REQ_QUERY, 16'sd0, 16'sd0);
		send_req(REQ_LOAD, 16'sh8000, 16'sh7fff);
		send_req(REQ_LOAD, 16'sh7fff, 16'sh8000);
		send_req(REQ_QUERY, 16'sd0, 16'sd0);
		send_req(REQ_QUERY, 16'sh8000, 16'sd0);
		send_req(REQ_QUERY, 16'sh7fff, 16'sd0);
		send_req(REQ_LOAD, 16'sd100, 16'sd5);
		send_req(REQ_LOAD, 16'sd100, 16'sd9);
		send_req(REQ_QUERY, 16'sd100, 16'sd0);
		send_req(REQ_QUERY, 16'sd99, 16'sd0);
		send_req(REQ_QUERY, 16'sd101, 16'sd0);
		send_req(REQ_NONE, 16'sd5, 16'sd5);
		send_req(REQ_CLEAR, 16'sd0, 16'sd0);
		send_req(REQ_QUERY, 16'sd100, 16'sd0);
		send_req(REQ_LOAD, 16'sd10, 16'sd1);
		send_req(REQ_QUERY, 16'sd9, 16'sd0);
		send_req(REQ_QUERY, 16'sd11, 16'sd0);
		for (int i = 0; i < TableDepth + 2; i++)
			send_req(REQ_LOAD, 16'($urandom), 16'($urandom));
		send_req(REQ_QUERY, 16'($urandom), 16'sd0);
		send_req(REQ_CLEAR, 16'sd0, 16'sd0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 73; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 73; end
				3: begin send_idle = 11; recv_stall = 11; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			if (ph == 4) begin
				// long receiver hold-off while the sender keeps offering
				hold_off = 1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int i = 0; i < 373; i++) rand_item();
		end
		in_valid <= 0;
		hold_off = 0;
		send_idle = 0;
		recv_stall = 0;
		while (sb.want_y.size() != 0) @(posedge clk);
		waited = 0;
		while (waited < 300) begin
			@(posedge clk);
			waited++;
		end
		if (sb.errors == 0 && sb.want_y.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
